// File: rtl/core/cen_pkg.sv
// Shared types, codes and helper functions of the CIGAR element normalizer.
`timescale 1ns / 1ps

package cen_pkg;

  localparam int unsigned OP_W = 4;
  localparam int unsigned LEN_W = 32 - OP_W;
  localparam int unsigned TOT_W = 32;
  localparam int unsigned PADDR_W = 3;

  // BAM operation codes.
  localparam logic [OP_W-1:0] OP_M = 4'd0;
  localparam logic [OP_W-1:0] OP_I = 4'd1;
  localparam logic [OP_W-1:0] OP_D = 4'd2;
  localparam logic [OP_W-1:0] OP_S = 4'd4;
  localparam logic [OP_W-1:0] OP_H = 4'd5;
  localparam logic [OP_W-1:0] OP_EQ = 4'd7;
  localparam logic [OP_W-1:0] OP_X = 4'd8;
  localparam logic [OP_W-1:0] OP_LAST_VALID = OP_X;
  localparam logic [OP_W-1:0] OP_NONE = 4'd15;

  // Item kinds.
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Register index (paddr bit 2).
  localparam logic REG_STRIP = 1'b0;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ORDER    = 3'd1,
    ST_SOFT_ALL = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SEC_LEFT_HARD  = 3'd0,
    SEC_LEFT_SOFT  = 3'd1,
    SEC_MIDDLE     = 3'd2,
    SEC_RIGHT_SOFT = 3'd3,
    SEC_RIGHT_HARD = 3'd4
  } sec_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [OP_W-1:0]  op;
  } elem_t;

  // Everything the emitter needs from a finish, apart from the counts.
  typedef struct packed {
    status_e          status;
    logic [TOT_W-1:0] lead;
    logic [TOT_W-1:0] trail;
    elem_t            tail0;
    elem_t            tail1;
  } job_t;

  function automatic logic is_clip(input logic [OP_W-1:0] op);
    return (op == OP_S) || (op == OP_H);
  endfunction

  function automatic logic eats_read(input logic [OP_W-1:0] op);
    return (op == OP_M) || (op == OP_I) || (op == OP_S) || (op == OP_EQ) || (op == OP_X);
  endfunction

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? '1 : s[LEN_W-1:0];
  endfunction

  function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] a,
                                               input logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? '1 : s[TOT_W-1:0];
  endfunction

endpackage

// File: rtl/core/cen_elem_mem.sv
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module cen_elem_mem import cen_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  elem_t             wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output elem_t             rdata_o
);

  elem_t mem_q [DEPTH];
  elem_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/cen_builder.sv
// Add-item update: section tracking, merging, deletion moves and spills to the store.
`timescale 1ns / 1ps

module cen_builder import cen_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 64,
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1),
  localparam int unsigned ADDR_W = $clog2(MAX_ELEMENTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              add_i,
  input  logic              fin_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic              allow_empty_i,
  input  logic              strip_i,
  output logic              mem_we_o,
  output logic [ADDR_W-1:0] mem_waddr_o,
  output elem_t             mem_wdata_o,
  output job_t              job_o,
  output logic [CNT_W-1:0]  job_mem_n_o,
  output logic [CNT_W-1:0]  job_beats_o,
  output logic [CNT_W-1:0]  job_count_o
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] One = CNT_W'(1);
  localparam logic [CNT_W-1:0] Two = CNT_W'(2);

  // The two newest entries live in registers; older ones are spilled to the store.
  logic [CNT_W-1:0] cnt_q, cnt_d;
  elem_t            e1_q, e1_d;   // entry cnt-1
  elem_t            e2_q, e2_d;   // entry cnt-2
  logic [OP_W-1:0]  prev_q, prev_d;
  sec_e             sec_q, sec_d;
  logic [TOT_W-1:0] lead_q, lead_d;
  logic [TOT_W-1:0] trail_q, trail_d;
  status_e          err_q, err_d;

  sec_e             sec_nx;
  logic             sec_ok;
  logic             first_del;
  logic             after_ins;
  logic             del_ins;
  logic             push_req;
  logic             ins_req;
  elem_t            new_elem;

  // Finish evaluation.
  logic [OP_W-1:0]  op0;
  logic             soft_all;
  logic             drop_last;
  logic             drop_prev;
  logic [LEN_W-1:0] in_finish;
  logic [1:0]       tail_n;
  elem_t            tail0;
  elem_t            tail1;
  logic [CNT_W-1:0] mem_n;
  logic [CNT_W-1:0] final_n;
  status_e          fin_status;

  assign new_elem = '{len: len_i, op: op_i};
  assign del_ins = (prev_q == OP_I) && (cnt_q > One) && (e2_q.op == OP_D);

  // Clip section advance.
  always_comb begin
    sec_ok = 1'b1;
    sec_nx = sec_q;
    if (op_i == OP_H) begin
      case (sec_q) inside
        SEC_LEFT_SOFT, SEC_MIDDLE, SEC_RIGHT_SOFT: sec_nx = SEC_RIGHT_HARD;
        default: sec_nx = sec_q;
      endcase
    end else if (op_i == OP_S) begin
      case (sec_q) inside
        SEC_RIGHT_HARD: sec_ok = 1'b0;
        SEC_LEFT_HARD:  sec_nx = SEC_LEFT_SOFT;
        SEC_MIDDLE:     sec_nx = SEC_RIGHT_SOFT;
        default:        sec_nx = sec_q;
      endcase
    end else begin
      case (sec_q) inside
        SEC_RIGHT_SOFT, SEC_RIGHT_HARD: sec_ok = 1'b0;
        SEC_LEFT_HARD, SEC_LEFT_SOFT:   sec_nx = SEC_MIDDLE;
        default:                        sec_nx = sec_q;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    e1_d = e1_q;
    e2_d = e2_q;
    prev_d = prev_q;
    sec_d = sec_q;
    lead_d = lead_q;
    trail_d = trail_q;
    err_d = err_q;
    push_req = 1'b0;
    ins_req = 1'b0;
    mem_we_o = 1'b0;
    mem_waddr_o = ADDR_W'(cnt_q - Two);
    mem_wdata_o = e2_q;

    first_del = (prev_q == OP_NONE) || (cnt_q == '0) || is_clip(prev_q);
    after_ins = (prev_q == OP_I) &&
                ((cnt_q == One) || ((cnt_q >= Two) && is_clip(e2_q.op)));

    if (add_i && (err_q == ST_OK) && (len_i != '0)) begin
      if (op_i > OP_LAST_VALID) begin
        err_d = ST_ORDER;
      end else if (strip_i && (op_i == OP_D) && (first_del || after_ins)) begin
        lead_d = sat_tot(lead_q, TOT_W'(len_i));
      end else if (!sec_ok) begin
        err_d = ST_ORDER;
      end else begin
        sec_d = sec_nx;
        if ((cnt_q == '0) || (prev_q == OP_NONE)) begin
          push_req = 1'b1;
        end else if (op_i == prev_q) begin
          e1_d.len = sat_len(e1_q.len, len_i);
        end else if (is_clip(op_i)) begin
          if (strip_i && !eats_read(prev_q) && !is_clip(prev_q)) begin
            // A trailing deletion or skip before the clip is dropped.
            trail_d = sat_tot(trail_q, TOT_W'(e1_q.len));
            e1_d = new_elem;
            prev_d = op_i;
          end else if (strip_i && del_ins) begin
            trail_d = sat_tot(trail_q, TOT_W'(e2_q.len));
            e2_d = e1_q;
            e1_d = new_elem;
            prev_d = op_i;
          end else begin
            push_req = 1'b1;
          end
        end else if ((op_i == OP_D) && (prev_q == OP_I)) begin
          if ((cnt_q > One) && (e2_q.op == OP_D)) begin
            e2_d.len = sat_len(e2_q.len, len_i);
          end else if (cnt_q >= MaxCnt) begin
            err_d = ST_OVERFLOW;
          end else begin
            ins_req = 1'b1;
          end
        end else begin
          push_req = 1'b1;
        end
      end
    end

    if (push_req) begin
      if (cnt_q >= MaxCnt) begin
        err_d = ST_OVERFLOW;
      end else begin
        e2_d = e1_q;
        e1_d = new_elem;
        cnt_d = cnt_q + One;
        prev_d = op_i;
        mem_we_o = (cnt_q >= Two);
      end
    end

    // The deletion goes in ahead of the insertion, which stays newest.
    if (ins_req) begin
      e2_d = '{len: len_i, op: OP_D};
      cnt_d = cnt_q + One;
      mem_we_o = (cnt_q >= Two);
    end

    if (fin_i) begin
      cnt_d = '0;
      prev_d = OP_NONE;
      sec_d = SEC_LEFT_HARD;
      lead_d = '0;
      trail_d = '0;
      err_d = ST_OK;
    end
  end

  // Finish: in the left soft section there are at most two entries, none of them in
  // the store, so the first entry is always one of the registers.
  always_comb begin
    op0 = (cnt_q == One) ? e1_q.op : e2_q.op;
    soft_all = (err_q == ST_OK) && (sec_q == SEC_LEFT_SOFT) && (cnt_q != '0) && (op0 == OP_S);
    drop_last = (err_q == ST_OK) && !soft_all && strip_i && (prev_q == OP_D) &&
                (cnt_q != '0);
    drop_prev = (err_q == ST_OK) && !soft_all && !drop_last && strip_i && del_ins;
    in_finish = drop_last ? e1_q.len : (drop_prev ? e2_q.len : '0);

    tail0 = e2_q;
    tail1 = e1_q;
    tail_n = 2'd0;
    if (cnt_q == One) begin
      tail0 = e1_q;
      tail_n = drop_last ? 2'd0 : 2'd1;
    end else if (cnt_q >= Two) begin
      if (drop_last) begin
        tail_n = 2'd1;
      end else if (drop_prev) begin
        tail0 = e1_q;
        tail_n = 2'd1;
      end else begin
        tail_n = 2'd2;
      end
    end
    mem_n = (cnt_q >= Two) ? (cnt_q - Two) : '0;
    final_n = mem_n + CNT_W'(tail_n);

    if (err_q != ST_OK) begin
      fin_status = err_q;
    end else if (soft_all) begin
      fin_status = ST_SOFT_ALL;
    end else if ((final_n == '0) && !allow_empty_i) begin
      fin_status = ST_EMPTY;
    end else begin
      fin_status = ST_OK;
    end

    job_o.status = fin_status;
    job_o.lead = lead_q;
    job_o.trail = sat_tot(trail_q, TOT_W'(in_finish));
    job_o.tail0 = tail0;
    job_o.tail1 = tail1;
    job_mem_n_o = mem_n;
    job_beats_o = final_n;
    job_count_o = (fin_status == ST_OK) ? final_n : '0;
    // An error or an accepted empty cigar gives one all-zero beat.
    if ((fin_status != ST_OK) || (final_n == '0)) begin
      job_o.tail0 = '0;
      job_mem_n_o = '0;
      job_beats_o = One;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      prev_q <= OP_NONE;
      sec_q <= SEC_LEFT_HARD;
      lead_q <= '0;
      trail_q <= '0;
      err_q <= ST_OK;
    end else begin
      cnt_q <= cnt_d;
      prev_q <= prev_d;
      sec_q <= sec_d;
      lead_q <= lead_d;
      trail_q <= trail_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_q <= e1_d;
    e2_q <= e2_d;
  end

endmodule

// File: rtl/core/cen_emitter.sv
// Finish sequencer: reads the store in order, appends the register tail, drives result beats.
`timescale 1ns / 1ps

module cen_emitter import cen_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 64,
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1),
  localparam int unsigned ADDR_W = $clog2(MAX_ELEMENTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  job_t              job_i,
  input  logic [CNT_W-1:0]  job_mem_n_i,
  input  logic [CNT_W-1:0]  job_beats_i,
  input  logic [CNT_W-1:0]  job_count_i,
  output logic              busy_o,
  output logic              mem_re_o,
  output logic [ADDR_W-1:0] mem_raddr_o,
  input  elem_t             mem_rdata_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output elem_t             out_elem_o,
  output logic              out_last_o,
  output status_e           status_o,
  output logic [TOT_W-1:0]  lead_o,
  output logic [TOT_W-1:0]  trail_o,
  output logic [CNT_W-1:0]  count_o
);

  localparam logic [CNT_W-1:0] One = CNT_W'(1);

  logic              busy_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  mem_left_q;
  logic [ADDR_W-1:0] rd_addr_q;
  elem_t             tail0_q;
  elem_t             tail1_q;
  job_t              info_q;
  logic [CNT_W-1:0]  count_q;

  // Fetch stage: either the store's read data or a tail register.
  logic              stg_v_q;
  logic              stg_mem_q;
  elem_t             stg_reg_q;
  logic              stg_last_q;

  logic              out_v_q;
  elem_t             out_q;
  logic              out_last_q;

  logic              stg_take;
  logic              issue;
  logic              from_mem;
  logic              out_done;

  assign stg_take = stg_v_q && (!out_v_q || !out_stall_i);
  assign issue = busy_q && (rem_q != '0) && (!stg_v_q || stg_take);
  assign from_mem = (mem_left_q != '0);
  assign out_done = out_v_q && !out_stall_i && out_last_q;

  assign mem_re_o = issue && from_mem;
  assign mem_raddr_o = rd_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q <= '0;
      mem_left_q <= '0;
      rd_addr_q <= '0;
      stg_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        rem_q <= job_beats_i;
        mem_left_q <= job_mem_n_i;
        rd_addr_q <= '0;
      end else begin
        if (out_done) begin
          busy_q <= 1'b0;
        end
        if (issue) begin
          rem_q <= rem_q - One;
          if (from_mem) begin
            mem_left_q <= mem_left_q - One;
            rd_addr_q <= rd_addr_q + ADDR_W'(1);
          end
        end
      end
      if (issue) begin
        stg_v_q <= 1'b1;
      end else if (stg_take) begin
        stg_v_q <= 1'b0;
      end
      if (stg_take) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      tail0_q <= job_i.tail0;
      tail1_q <= job_i.tail1;
      info_q <= job_i;
      count_q <= job_count_i;
    end else if (issue && !from_mem) begin
      tail0_q <= tail1_q;
    end
    if (issue) begin
      stg_mem_q <= from_mem;
      stg_reg_q <= tail0_q;
      stg_last_q <= (rem_q == One);
    end
    if (stg_take) begin
      out_q <= stg_mem_q ? mem_rdata_i : stg_reg_q;
      out_last_q <= stg_last_q;
    end
  end

  assign busy_o = busy_q;
  assign out_valid_o = out_v_q;
  assign out_elem_o = out_q;
  assign out_last_o = out_last_q;
  assign status_o = info_q.status;
  assign lead_o = info_q.lead;
  assign trail_o = info_q.trail;
  assign count_o = count_q;

endmodule

// File: rtl/core/cigar_element_normalizer_unit.sv
// Top level of the CIGAR element normalizer: channels, register port and submodules.
`timescale 1ns / 1ps

// Normalizes a CIGAR given one element per add beat and emits it on a finish beat.
// An add beat gives no result; the two newest elements sit in registers and older
// ones are written to a MAX_ELEMENTS-entry store, at most one write per add. A
// finish beat holds the input side until its last result beat leaves: the store is
// read once per cycle and the output register turns out one result beat per cycle
// while out_stall_i is low, the final one with last set. Errors and an accepted
// empty cigar give a single all-zero beat. The status, removed-base totals and
// element count hold steady over all beats of a finish.
// strip_end_deletions sits at byte address 0 and resets to one.

module cigar_element_normalizer_unit import cen_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 64,
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1),
  localparam int unsigned ADDR_W = $clog2(MAX_ELEMENTS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Register port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [OP_W-1:0]    op_code_i,
  input  logic [LEN_W-1:0]   op_length_i,
  input  logic               allow_empty_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OP_W-1:0]    out_op_o,
  output logic [LEN_W-1:0]   out_length_o,
  output logic               last_o,
  output logic [2:0]         status_o,
  output logic [TOT_W-1:0]   leading_removed_o,
  output logic [TOT_W-1:0]   trailing_removed_o,
  output logic [CNT_W-1:0]   element_count_o
);

  logic              strip_q;
  logic              cfg_wr;
  logic              in_fire;
  logic              add_fire;
  logic              fin_fire;
  logic              busy;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  elem_t             mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  elem_t             mem_rdata;

  job_t              job;
  logic [CNT_W-1:0]  job_mem_n;
  logic [CNT_W-1:0]  job_beats;
  logic [CNT_W-1:0]  job_count;
  elem_t             out_elem;
  status_e           out_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_STRIP: strip_q <= pwdata[0];
        default: strip_q <= strip_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STRIP: prdata = {31'd0, strip_q};
      default: prdata = '0;
    endcase
  end

  assign in_stall_o = busy;
  assign in_fire = in_valid_i && !busy;
  assign add_fire = in_fire && (kind_i == KIND_ADD);
  assign fin_fire = in_fire && (kind_i == KIND_FINISH);

  cen_builder #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_builder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .add_i         (add_fire),
    .fin_i         (fin_fire),
    .op_i          (op_code_i),
    .len_i         (op_length_i),
    .allow_empty_i (allow_empty_i),
    .strip_i       (strip_q),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .job_o         (job),
    .job_mem_n_o   (job_mem_n),
    .job_beats_o   (job_beats),
    .job_count_o   (job_count)
  );

  // Writes happen only on add beats and reads only while a finish drains,
  // so the two ports never touch the store at the same time.
  cen_elem_mem #(
    .DEPTH(MAX_ELEMENTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cen_emitter #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (fin_fire),
    .job_i       (job),
    .job_mem_n_i (job_mem_n),
    .job_beats_i (job_beats),
    .job_count_i (job_count),
    .busy_o      (busy),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_elem_o  (out_elem),
    .out_last_o  (last_o),
    .status_o    (out_status),
    .lead_o      (leading_removed_o),
    .trail_o     (trailing_removed_o),
    .count_o     (element_count_o)
  );

  assign out_op_o = out_elem.op;
  assign out_length_o = out_elem.len;
  assign status_o = out_status;

endmodule
